// ----- rtl/bq_pkg.sv -----
// ----------------------------------------------------------------------------
// bq_pkg: shared types, sizes and helpers of the biquad filter
// Fixed-point sizes, register indexes, control structs and delay saturation.
// ----------------------------------------------------------------------------
package bq_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int FRAC_BITS  = 15;
  localparam int ACC_W      = SAMPLE_W + 24;
  localparam int SUM_W      = ACC_W + 2;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int DIGIT_W    = 2;
  localparam int NUM_DIGITS = SAMPLE_W / DIGIT_W;
  localparam int CNT_W      = $clog2(NUM_DIGITS);
  localparam int NUM_COEFS  = 5;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_B0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_B1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_B2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_A1 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_A2 = CFG_IDX_W'(4);

  localparam logic [COEF_W-1:0] COEF_ONE   = COEF_W'(1) << FRAC_BITS;
  localparam logic [ACC_W:0]    ROUND_HALF = (ACC_W + 1)'(1) << (FRAC_BITS - 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  typedef struct packed {
    logic en;
    logic first;
  } mul_ctl_t;

  typedef struct packed {
    sample_t sample_out;
    logic    clipped;
  } result_t;

  function automatic acc_t sat_acc(input sum_t v);
    logic same;
    same = (&v[SUM_W-1:ACC_W-1]) || !(|v[SUM_W-1:ACC_W-1]);
    if (same) begin
      return v[ACC_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction

endpackage

// ----- rtl/bq_serial_mul.sv -----
// ----------------------------------------------------------------------------
// bq_serial_mul: radix-4 digit-serial multiplier
// Takes the sample two bits a cycle, most significant digit first, and folds
// each digit times the coefficient into a Horner accumulator.
// ----------------------------------------------------------------------------
module bq_serial_mul (
  input  logic                        clk,
  input  bq_pkg::coef_t               coef,
  input  logic [bq_pkg::DIGIT_W-1:0]  digit,
  input  bq_pkg::mul_ctl_t            ctl,
  output bq_pkg::prod_t               prod
);

  bq_pkg::prod_t lo;
  bq_pkg::prod_t hi;
  bq_pkg::prod_t term;
  bq_pkg::prod_t base;

  always_comb begin
    lo   = digit[0] ? bq_pkg::PROD_W'(coef) : '0;
    hi   = digit[1] ? (bq_pkg::PROD_W'(coef) <<< 1) : '0;
    // top digit carries the sign weight
    term = ctl.first ? (lo - hi) : (lo + hi);
    base = ctl.first ? '0 : (prod <<< bq_pkg::DIGIT_W);
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod <= base + term;
    end
  end

endmodule

// ----- rtl/bq_core.sv -----
// ----------------------------------------------------------------------------
// bq_core: transposed direct form II sequencer and delay state
// Runs the feedforward products, forms the rounded saturated output, runs the
// feedback products and updates both delay words.
// ----------------------------------------------------------------------------
module bq_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            clr,
  input  logic            start,
  input  bq_pkg::sample_t sample,
  input  bq_pkg::coef_t   coef_b0,
  input  bq_pkg::coef_t   coef_b1,
  input  bq_pkg::coef_t   coef_b2,
  input  bq_pkg::coef_t   coef_a1,
  input  bq_pkg::coef_t   coef_a2,
  output logic            idle,
  output logic            res_valid,
  output bq_pkg::result_t res,
  input  logic            res_take
);

  typedef enum logic [2:0] {
    S_IDLE, S_XMUL, S_YRES, S_YMUL, S_UPD, S_HOLD
  } state_t;

  state_t                    state;
  logic [bq_pkg::CNT_W-1:0]  cnt;
  bq_pkg::sample_t           xs;
  bq_pkg::sample_t           ys;
  bq_pkg::acc_t              delay_one;
  bq_pkg::acc_t              delay_two;
  bq_pkg::prod_t             p0, p1, p2, q1, q2;
  bq_pkg::mul_ctl_t          x_ctl, y_ctl;
  logic [bq_pkg::DIGIT_W-1:0] x_digit, y_digit;

  logic signed [bq_pkg::ACC_W:0]                  ysum;
  logic signed [bq_pkg::ACC_W-bq_pkg::FRAC_BITS:0] yshift;
  logic                                           y_ok;
  bq_pkg::sample_t                                y_sat;
  bq_pkg::sum_t                                   t1, t2;
  logic                                           last_digit;

  assign x_digit    = xs[bq_pkg::SAMPLE_W-1 -: bq_pkg::DIGIT_W];
  assign y_digit    = ys[bq_pkg::SAMPLE_W-1 -: bq_pkg::DIGIT_W];
  assign last_digit = (cnt == bq_pkg::CNT_W'(bq_pkg::NUM_DIGITS - 1));

  assign x_ctl.en    = (state == S_XMUL);
  assign x_ctl.first = (cnt == '0);
  assign y_ctl.en    = (state == S_YMUL);
  assign y_ctl.first = (cnt == '0);

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_HOLD);

  bq_serial_mul u_mul_b0 (.clk(clk), .coef(coef_b0), .digit(x_digit), .ctl(x_ctl), .prod(p0));
  bq_serial_mul u_mul_b1 (.clk(clk), .coef(coef_b1), .digit(x_digit), .ctl(x_ctl), .prod(p1));
  bq_serial_mul u_mul_b2 (.clk(clk), .coef(coef_b2), .digit(x_digit), .ctl(x_ctl), .prod(p2));
  bq_serial_mul u_mul_a1 (.clk(clk), .coef(coef_a1), .digit(y_digit), .ctl(y_ctl), .prod(q1));
  bq_serial_mul u_mul_a2 (.clk(clk), .coef(coef_a2), .digit(y_digit), .ctl(y_ctl), .prod(q2));

  always_comb begin
    ysum   = (bq_pkg::ACC_W + 1)'(p0) + (bq_pkg::ACC_W + 1)'(delay_one) + bq_pkg::ROUND_HALF;
    yshift = ysum[bq_pkg::ACC_W:bq_pkg::FRAC_BITS];
    y_ok   = (&yshift[bq_pkg::ACC_W-bq_pkg::FRAC_BITS:bq_pkg::SAMPLE_W-1]) ||
             !(|yshift[bq_pkg::ACC_W-bq_pkg::FRAC_BITS:bq_pkg::SAMPLE_W-1]);
    if (y_ok) begin
      y_sat = yshift[bq_pkg::SAMPLE_W-1:0];
    end else if (yshift[bq_pkg::ACC_W-bq_pkg::FRAC_BITS]) begin
      y_sat = {1'b1, {(bq_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(bq_pkg::SAMPLE_W-1){1'b1}}};
    end
    t1 = bq_pkg::SUM_W'(p1) - bq_pkg::SUM_W'(q1) + bq_pkg::SUM_W'(delay_two);
    t2 = bq_pkg::SUM_W'(p2) - bq_pkg::SUM_W'(q2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      delay_one <= '0;
      delay_two <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            xs    <= sample;
            cnt   <= '0;
            state <= S_XMUL;
          end
        end
        S_XMUL: begin
          xs  <= xs <<< bq_pkg::DIGIT_W;
          cnt <= cnt + 1'b1;
          if (last_digit) begin
            state <= S_YRES;
          end
        end
        S_YRES: begin
          ys             <= y_sat;
          res.sample_out <= y_sat;
          res.clipped    <= !y_ok;
          cnt            <= '0;
          state          <= S_YMUL;
        end
        S_YMUL: begin
          ys  <= ys <<< bq_pkg::DIGIT_W;
          cnt <= cnt + 1'b1;
          if (last_digit) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          delay_one <= bq_pkg::sat_acc(t1);
          delay_two <= bq_pkg::sat_acc(t2);
          state     <= S_HOLD;
        end
        S_HOLD: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (clr) begin
        delay_one <= '0;
        delay_two <= '0;
      end
    end
  end

endmodule

// ----- rtl/biquad_tdf2_filter.sv -----
// ----------------------------------------------------------------------------
// biquad_tdf2_filter: second-order IIR section, transposed direct form II
// Samples enter on the s_axis beat and leave on the m_axis beat, one result
// beat per input beat, in order. tdata carries the signed 16-bit sample;
// m_axis_tuser is high when the output saturated.
// Coefficients b0, b1, b2, a1, a2 (signed Q2.15) are written through
// cfg_we/cfg_index/cfg_data at indexes 0 to 4; any such write clears both
// delay words. Indexes 5 to 7 are ignored. Write only while the filter is idle.
// From accept to the result register each sample passes through the states
// S_XMUL (radix-4 digits of the feedforward products), S_YRES (rounding and
// saturation), S_YMUL (digits of the feedback products), S_UPD (delay update)
// and S_HOLD (transfer). The feedback products need the finished output, so
// the two digit-serial passes run back to back, and a new sample is taken
// only once the previous one has left the core.
// A stalled receiver holds the result register; the core parks one further
// finished result behind it, then stops accepting.
// Reset (rst, synchronous) restores unity passthrough, clears the delays and
// empties the output register.
// ----------------------------------------------------------------------------
module biquad_tdf2_filter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // [15:0] sample_in
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // [15:0] sample_out
  output logic                           m_axis_tuser,  // [0] clipped
  input  logic                           cfg_we,
  input  logic [bq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bq_pkg::COEF_W-1:0]      cfg_data
);

  bq_pkg::coef_t   coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic            core_idle;
  logic            res_valid;
  logic            res_take;
  logic            clr;
  bq_pkg::result_t res;

  assign s_axis_tready = core_idle;
  assign res_take      = res_valid && (!m_axis_tvalid || m_axis_tready);
  assign clr           = cfg_we && (cfg_index < bq_pkg::CFG_IDX_W'(bq_pkg::NUM_COEFS));

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= bq_pkg::COEF_ONE;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bq_pkg::REG_B0: coef_b0 <= cfg_data;
        bq_pkg::REG_B1: coef_b1 <= cfg_data;
        bq_pkg::REG_B2: coef_b2 <= cfg_data;
        bq_pkg::REG_A1: coef_a1 <= cfg_data;
        bq_pkg::REG_A2: coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  bq_core u_core (
    .clk       (clk),
    .rst       (rst),
    .clr       (clr),
    .start     (s_axis_tvalid && s_axis_tready),
    .sample    (s_axis_tdata),
    .coef_b0   (coef_b0),
    .coef_b1   (coef_b1),
    .coef_b2   (coef_b2),
    .coef_a1   (coef_a1),
    .coef_a2   (coef_a2),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // hold the result beat until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_axis_tdata <= res.sample_out;
      m_axis_tuser <= res.clipped;
    end
  end

endmodule
